[rtl/assert_macros.svh]
// Shared assertion macros, sampled on clk_i, off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KIF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("kif assertion failed");

`define KIF_NEVER(lbl, cond) `KIF_ASSERT(lbl, !(cond))

`endif

[rtl/kif_pkg.sv]
package kif_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 4096;
  localparam int ColW      = 10;
  localparam int RowW      = 12;
  localparam int QDepth    = 4;

  localparam logic [3:0] KSEL_GAUSS = 4'd0;
  localparam logic [3:0] KSEL_BOX   = 4'd1;
  localparam logic [3:0] KSEL_MAX   = 4'd10;

  localparam logic [1:0] CFG_KSEL   = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  // floor(x/9) == (x*3641)>>15 for 0..2295
  localparam logic [11:0] RECIP9 = 12'd3641;

  localparam logic signed [4:0] KERN_TAB [0:10][0:8] = '{
    '{ 5'sd1,  5'sd2,  5'sd1,  5'sd2,  5'sd4,  5'sd2,  5'sd1,  5'sd2,  5'sd1},
    '{ 5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1,  5'sd1},
    '{-5'sd1, -5'sd2, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd2,  5'sd1},
    '{ 5'sd1,  5'sd0, -5'sd1,  5'sd2,  5'sd0, -5'sd2,  5'sd1,  5'sd0, -5'sd1},
    '{-5'sd1, -5'sd1, -5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd1,  5'sd1},
    '{-5'sd1,  5'sd0,  5'sd1, -5'sd1,  5'sd0,  5'sd1, -5'sd1,  5'sd0,  5'sd1},
    '{-5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{ 5'sd0,  5'sd0, -5'sd1,  5'sd0,  5'sd1,  5'sd0,  5'sd0,  5'sd0,  5'sd0},
    '{ 5'sd0, -5'sd1,  5'sd0, -5'sd1,  5'sd4, -5'sd1,  5'sd0, -5'sd1,  5'sd0},
    '{-5'sd1, -5'sd1, -5'sd1, -5'sd1,  5'sd8, -5'sd1, -5'sd1, -5'sd1, -5'sd1},
    '{ 5'sd0, -5'sd2, -5'sd2,  5'sd2,  5'sd0, -5'sd2,  5'sd2,  5'sd2,  5'sd0}
  };

  typedef struct packed {
    logic [8:0][7:0]  win;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last_col;
    logic             last_row;
  } kif_job_t;

endpackage

[rtl/kif_ram.sv]
module kif_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kif_front.sv]
module kif_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    restart_i,
  input  logic [10:0]             width_i,
  input  logic [12:0]             height_i,
  input  logic                    accept_i,
  input  logic [7:0]              pixel_i,
  output logic                    busy_o,
  output logic                    push_o,
  output kif_pkg::kif_job_t       job_o
);

  localparam int AddrW = $clog2(kif_pkg::MaxWidth);

  logic [kif_pkg::ColW-1:0] col_q, col_d, c_eff, a_col_q;
  logic [kif_pkg::RowW-1:0] row_q, row_d, r_eff, a_row_q;
  logic                     a_vld_q, a_lc_q, a_lr_q;
  logic [7:0]               a_px_q;
  logic [8:0][7:0]          win_q, win_d;
  logic [10:0]              c_inc;
  logic [12:0]              r_inc;
  logic [15:0]              rd_data;

  always_comb begin
    c_eff = ({1'b0, col_q} >= width_i) ? '0 : col_q;
    r_eff = ({1'b0, row_q} >= height_i) ? '0 : row_q;
    c_inc = {1'b0, c_eff} + 11'd1;
    r_inc = {1'b0, r_eff} + 13'd1;
    col_d = c_inc[kif_pkg::ColW-1:0];
    row_d = r_eff;
    if (c_inc == width_i) begin
      col_d = '0;
      row_d = (r_inc == height_i) ? '0 : r_inc[kif_pkg::RowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      a_vld_q <= 1'b0;
      win_q   <= '0;
    end else begin
      a_vld_q <= accept_i;
      if (restart_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (a_vld_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_px_q  <= pixel_i;
      a_col_q <= c_eff;
      a_row_q <= r_eff;
      a_lc_q  <= ({1'b0, c_eff} == width_i - 11'd1);
      a_lr_q  <= ({1'b0, r_eff} == height_i - 13'd1);
    end
  end

  kif_ram #(
    .Width(16),
    .Depth(kif_pkg::MaxWidth)
  ) u_lines (
    .clk_i  (clk_i),
    .we_i   (a_vld_q),
    .waddr_i(a_col_q[AddrW-1:0]),
    .wdata_i({rd_data[7:0], a_px_q}),
    .raddr_i(c_eff[AddrW-1:0]),
    .rdata_o(rd_data)
  );

  always_comb begin
    win_d = win_q;
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]   = win_q[i*3+1];
      win_d[i*3+1] = win_q[i*3+2];
    end
    win_d[2] = rd_data[15:8];
    win_d[5] = rd_data[7:0];
    win_d[8] = a_px_q;
  end

  assign push_o         = a_vld_q && (a_row_q != '0) && (a_col_q != '0);
  assign job_o.win      = win_d;
  assign job_o.row      = a_row_q;
  assign job_o.col      = a_col_q;
  assign job_o.last_col = a_lc_q;
  assign job_o.last_row = a_lr_q;
  assign busy_o         = a_vld_q;

endmodule

[rtl/kif_queue.sv]
`include "assert_macros.svh"

module kif_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kif_pkg::kif_job_t job_i,
  input  logic              pop_i,
  output logic              valid_o,
  output kif_pkg::kif_job_t job_o,
  output logic [2:0]        count_o
);

  kif_pkg::kif_job_t mem_q [kif_pkg::QDepth];
  logic [1:0]        wptr_q, rptr_q;
  logic [2:0]        cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 2'd1;
      if (pop_i)  rptr_q <= rptr_q + 2'd1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rptr_q];
  assign count_o = cnt_q;

  `KIF_NEVER(a_q_overflow, push_i && !pop_i && cnt_q == 3'(kif_pkg::QDepth))
  `KIF_NEVER(a_q_underflow, pop_i && cnt_q == '0)
  `KIF_ASSERT(a_q_count, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 3'd1))

endmodule

[rtl/kif_back.sv]
`include "assert_macros.svh"

module kif_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        ksel_i,
  input  logic              job_vld_i,
  input  kif_pkg::kif_job_t job_i,
  output logic              pop_o,
  output logic              out_vld_o,
  input  logic              out_rdy_i,
  output logic [7:0]        pixel_o,
  output logic [kif_pkg::RowW-1:0] row_o,
  output logic [kif_pkg::ColW-1:0] col_o,
  output logic              last_o
);

  logic [3:0]  done_q, mask, rem;
  logic [1:0]  k;
  logic        adv, issue, final_em;
  logic [1:0]  rs [3];
  logic [1:0]  cs [3];
  logic [7:0]  p [9];
  logic signed [13:0] sum, term;

  logic                     s1_vld_q, o_vld_q, s1_lst_q, o_lst_q;
  logic signed [13:0]       s1_sum_q;
  logic [3:0]               s1_ks_q;
  logic [kif_pkg::RowW-1:0] s1_row_q, o_row_q;
  logic [kif_pkg::ColW-1:0] s1_col_q, o_col_q;
  logic [7:0]               o_px_q, px_d;
  logic [12:0]              q;
  logic [24:0]              prod;

  assign adv      = !o_vld_q || out_rdy_i;
  assign mask     = {job_i.last_col & job_i.last_row, job_i.last_row, job_i.last_col, 1'b1};
  assign rem      = mask & ~done_q;
  assign issue    = adv && job_vld_i;
  assign final_em = (rem & (rem - 4'd1)) == '0;
  assign pop_o    = issue && final_em;

  always_comb begin
    k = 2'd3;
    if (rem[2]) k = 2'd2;
    if (rem[1]) k = 2'd1;
    if (rem[0]) k = 2'd0;
    rs[0] = k[1] ? 2'd1 : ((job_i.row == 12'd1) ? 2'd2 : 2'd0);
    rs[1] = k[1] ? 2'd2 : 2'd1;
    rs[2] = 2'd2;
    cs[0] = k[0] ? 2'd1 : ((job_i.col == 10'd1) ? 2'd2 : 2'd0);
    cs[1] = k[0] ? 2'd2 : 2'd1;
    cs[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p[i*3+j] = job_i.win[4'(rs[i]) * 4'd3 + 4'(cs[j])];
      end
    end
    sum = '0;
    for (int n = 0; n < 9; n++) begin
      term = (ksel_i > kif_pkg::KSEL_MAX) ? 14'sd0 :
             14'(kif_pkg::KERN_TAB[ksel_i][n]) * $signed({6'd0, p[n]});
      sum  = sum + term;
    end
  end

  always_comb begin
    prod = 25'(s1_sum_q[12:0]) * 25'(kif_pkg::RECIP9);
    if (s1_sum_q < 0 || s1_ks_q > kif_pkg::KSEL_MAX) begin
      q = '0;
    end else if (s1_ks_q == kif_pkg::KSEL_GAUSS) begin
      q = {4'd0, s1_sum_q[12:4]};
    end else if (s1_ks_q == kif_pkg::KSEL_BOX) begin
      q = {3'd0, prod[24:15]};
    end else begin
      q = s1_sum_q[12:0];
    end
    px_d = (q > 13'd255) ? 8'd255 : q[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= '0;
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (issue) begin
        done_q <= final_em ? '0 : (done_q | (4'd1 << k));
      end
      if (adv) begin
        s1_vld_q <= job_vld_i;
        o_vld_q  <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sum_q <= sum;
      s1_ks_q  <= ksel_i;
      s1_row_q <= k[1] ? job_i.row : job_i.row - 12'd1;
      s1_col_q <= k[0] ? job_i.col : job_i.col - 10'd1;
      s1_lst_q <= (k == 2'd3);
      o_px_q   <= px_d;
      o_row_q  <= s1_row_q;
      o_col_q  <= s1_col_q;
      o_lst_q  <= s1_lst_q;
    end
  end

  assign out_vld_o = o_vld_q;
  assign pixel_o   = o_px_q;
  assign row_o     = o_row_q;
  assign col_o     = o_col_q;
  assign last_o    = o_lst_q;

  `KIF_NEVER(a_b_done_not_sub, (done_q & ~mask) != '0 && job_vld_i)
  `KIF_ASSERT(a_b_hold, (o_vld_q && !out_rdy_i) |=> o_vld_q)

endmodule

[rtl/kernel3x3_image_filter_unit.sv]
// channel   | dir | beat payload
// s_axis    | in  | tdata[7:0] pixel_in
// m_axis    | out | tdata[7:0] pixel_out, [19:8] out_row, [29:20] out_col; tlast frame_last
// cfg       | in  | we, idx (0 kernel_select, 1 image_width, 2 image_height), data
// One pixel in per cycle sustained while the queue has room; each pixel yields 0..4 beats,
// one per cycle from the back pipeline while the sink is ready, so the last row stalls the input.
// Path: registered line-store read, queue, then 2 back stages to the output register.
// Input stalls when the 4-entry job queue plus the in-flight pixel would overflow.
// Reset clears counters, window and pipeline valids; line stores are not cleared.
module kernel3x3_image_filter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel_in
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] pixel_out, [19:8] out_row, [29:20] out_col
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  logic [3:0]  ksel_q;
  logic [10:0] width_q, w_eff;
  logic [12:0] height_q, h_eff;
  logic        restart, accept, push, busy, pop, q_vld;
  logic [2:0]  q_cnt;
  kif_pkg::kif_job_t job_in, job_out;
  logic [7:0]  px;
  logic [kif_pkg::RowW-1:0] orow;
  logic [kif_pkg::ColW-1:0] ocol;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ksel_q   <= '0;
      width_q  <= 11'd512;
      height_q <= 13'd512;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kif_pkg::CFG_KSEL:   ksel_q   <= cfg_data_i[3:0];
        kif_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[10:0];
        kif_pkg::CFG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == kif_pkg::CFG_WIDTH ||
                                cfg_idx_i == kif_pkg::CFG_HEIGHT);
  assign w_eff = (width_q < 11'd2) ? 11'd2 :
                 (width_q > 11'(kif_pkg::MaxWidth)) ? 11'(kif_pkg::MaxWidth) : width_q;
  assign h_eff = (height_q < 13'd2) ? 13'd2 :
                 (height_q > 13'(kif_pkg::MaxHeight)) ? 13'(kif_pkg::MaxHeight) : height_q;

  assign s_axis_tready_o = (q_cnt + 3'(busy)) < 3'(kif_pkg::QDepth);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  kif_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .restart_i(restart),
    .width_i  (w_eff),
    .height_i (h_eff),
    .accept_i (accept),
    .pixel_i  (s_axis_tdata_i),
    .busy_o   (busy),
    .push_o   (push),
    .job_o    (job_in)
  );

  kif_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .valid_o(q_vld),
    .job_o  (job_out),
    .count_o(q_cnt)
  );

  kif_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ksel_i   (ksel_q),
    .job_vld_i(q_vld),
    .job_i    (job_out),
    .pop_o    (pop),
    .out_vld_o(m_axis_tvalid_o),
    .out_rdy_i(m_axis_tready_i),
    .pixel_o  (px),
    .row_o    (orow),
    .col_o    (ocol),
    .last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, ocol, orow, px};

endmodule

[bench/kernel3x3_image_filter_unit_tb.sv]
`timescale 1ns / 1ps

module kernel3x3_image_filter_unit_tb;

  localparam int CycleLimit = 2000000;
  localparam int Settle     = 20;

  typedef struct {
    logic [7:0]               pix;
    logic [kif_pkg::RowW-1:0] row;
    logic [kif_pkg::ColW-1:0] col;
    logic                     last;
  } pix_beat_t;

  class filter_scoreboard;
    int unsigned ksel, wid, hgt, row, col;
    logic [7:0] upper [kif_pkg::MaxWidth];
    logic [7:0] middle [kif_pkg::MaxWidth];
    logic [7:0] win [9];
    pix_beat_t  exp_q [$];
    int errors, beats;
    int kt [11][9] = '{
      '{ 1, 2, 1, 2, 4, 2, 1, 2, 1}, '{ 1, 1, 1, 1, 1, 1, 1, 1, 1},
      '{-1,-2,-1, 0, 0, 0, 1, 2, 1}, '{ 1, 0,-1, 2, 0,-2, 1, 0,-1},
      '{-1,-1,-1, 0, 0, 0, 1, 1, 1}, '{-1, 0, 1,-1, 0, 1,-1, 0, 1},
      '{-1, 0, 0, 0, 1, 0, 0, 0, 0}, '{ 0, 0,-1, 0, 1, 0, 0, 0, 0},
      '{ 0,-1, 0,-1, 4,-1, 0,-1, 0}, '{-1,-1,-1,-1, 8,-1,-1,-1,-1},
      '{ 0,-2,-2, 2, 0,-2, 2, 2, 0}};

    function new();
      ksel = kif_pkg::KSEL_GAUSS; wid = 512; hgt = 512; row = 0; col = 0;
      foreach (win[i]) win[i] = '0;
      foreach (upper[i]) begin
        upper[i] = '0; middle[i] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned v);
      case (idx)
        kif_pkg::CFG_KSEL: ksel = v & 4'hF;
        kif_pkg::CFG_WIDTH: begin
          wid = v & 11'h7FF; row = 0; col = 0;
        end
        kif_pkg::CFG_HEIGHT: begin
          hgt = v & 13'h1FFF; row = 0; col = 0;
        end
        default: ;
      endcase
    endfunction

    function void emit_at(int rt, int rm, int rb, int cl, int cm, int cr,
                          int unsigned orow, int unsigned ocol, bit last);
      int rs [3];
      int cs [3];
      int sum, q;
      pix_beat_t b;
      rs = '{rt, rm, rb};
      cs = '{cl, cm, cr};
      sum = 0;
      q = 0;
      if (ksel <= kif_pkg::KSEL_MAX) begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            sum += kt[ksel][i*3+j] * int'(win[rs[i]*3 + cs[j]]);
        if (sum > 0) begin
          q = (ksel == kif_pkg::KSEL_GAUSS) ? sum / 16 :
              (ksel == kif_pkg::KSEL_BOX) ? sum / 9 : sum;
          if (q > 255) q = 255;
        end
      end
      b.pix = q[7:0]; b.row = orow[kif_pkg::RowW-1:0]; b.col = ocol[kif_pkg::ColW-1:0];
      b.last = last;
      exp_q.push_back(b);
    endfunction

    function void note_pixel(logic [7:0] px);
      int unsigned w, h, r, c, rt, cl;
      logic [7:0] top, mid;
      w = (wid < 2) ? 2 : (wid > kif_pkg::MaxWidth) ? kif_pkg::MaxWidth : wid;
      h = (hgt < 2) ? 2 : (hgt > kif_pkg::MaxHeight) ? kif_pkg::MaxHeight : hgt;
      r = (row >= h) ? 0 : row;
      c = (col >= w) ? 0 : col;
      top = upper[c]; mid = middle[c];
      upper[c] = mid; middle[c] = px;
      for (int i = 0; i < 3; i++) begin
        win[i*3] = win[i*3+1]; win[i*3+1] = win[i*3+2];
      end
      win[2] = top; win[5] = mid; win[8] = px;
      if (r >= 1 && c >= 1) begin
        rt = (r == 1) ? 2 : 0;
        cl = (c == 1) ? 2 : 0;
        emit_at(rt, 1, 2, cl, 1, 2, r-1, c-1, 0);
        if (c == w-1) emit_at(rt, 1, 2, 1, 2, 2, r-1, c, 0);
        if (r == h-1) begin
          emit_at(1, 2, 2, cl, 1, 2, r, c-1, 0);
          if (c == w-1) emit_at(1, 2, 2, 1, 2, 2, r, c, 1);
        end
      end
      c++;
      if (c >= w) begin
        c = 0; r++;
        if (r >= h) r = 0;
      end
      col = c; row = r;
    endfunction

    function void check_beat(logic [31:0] d, logic l);
      pix_beat_t e;
      beats++;
      if (exp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat data=%h last=%b", d, l);
        return;
      end
      e = exp_q.pop_front();
      if (d[7:0] !== e.pix || d[19:8] !== e.row || d[29:20] !== e.col || l !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp pix=%0d row=%0d col=%0d last=%b got pix=%0d row=%0d col=%0d last=%b",
                   e.pix, e.row, e.col, e.last, d[7:0], d[19:8], d[29:20], l);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [12:0] cfg_data_i = '0;

  filter_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  bit  hold_tog = 0, hold_seen = 0;
  int  hold_cnt = 0;

  kernel3x3_image_filter_unit u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit calm();
    return sent >= 40 && sent < 80;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_beat(m_axis_tdata_o, m_axis_tlast_o);
    if (hold_tog != hold_seen) begin
      hold_seen <= hold_tog;
      hold_cnt <= 400;
      m_axis_tready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= calm() || ($urandom_range(0, 99) >= 13);
    end
  end

  task automatic send_pixel(logic [7:0] px);
    if (!calm() && $urandom_range(0, 99) < 13) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= px;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_pixel(px);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.exp_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  task automatic set_geometry(int unsigned k, int unsigned w, int unsigned h);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= kif_pkg::CFG_KSEL; cfg_data_i <= 13'(k);
    @(posedge clk_i); sb.write_reg(kif_pkg::CFG_KSEL, k);
    cfg_idx_i <= kif_pkg::CFG_WIDTH; cfg_data_i <= 13'(w);
    @(posedge clk_i); sb.write_reg(kif_pkg::CFG_WIDTH, w);
    cfg_idx_i <= kif_pkg::CFG_HEIGHT; cfg_data_i <= 13'(h);
    @(posedge clk_i); sb.write_reg(kif_pkg::CFG_HEIGHT, h);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] rand_pix();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_frame(int unsigned k, int unsigned w, int unsigned h, int n);
    set_geometry(k, w, h);
    for (int i = 0; i < n; i++) send_pixel(rand_pix());
  endtask

  initial begin
    int w, h, n;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturated gauss, clamped 2x2 geometry, unused kernel, checker on the last kernel (KSEL_MAX)
    set_geometry(kif_pkg::KSEL_GAUSS, 3, 3);
    repeat (9) send_pixel(8'd255);
    set_geometry(9, 0, 1);
    for (int i = 0; i < 4; i++) send_pixel((i % 2) ? 8'd255 : 8'd0);
    run_frame(15, 2, 2, 4);
    set_geometry(kif_pkg::KSEL_MAX, 2, 2);
    for (int i = 0; i < 4; i++) send_pixel((i == 0 || i == 3) ? 8'd255 : 8'd0);

    while (sent < 90) begin
      w = $urandom_range(2, 5);
      h = $urandom_range(2, 4);
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, w*h) : w*h*$urandom_range(1, 2);
      run_frame($urandom_range(0, 15), w, h, n);
    end

    // wide frame with a long sink stall so the input backs up
    set_geometry(kif_pkg::KSEL_BOX, 16, 2);
    hold_tog = ~hold_tog;
    for (int i = 0; i < 32; i++) send_pixel(rand_pix());
    run_frame(3, 2047, 8191, 10);
    run_frame(8, 2, kif_pkg::MaxHeight, 10);
    run_frame(2, 1024, 2, 0);

    drain();
    $display("%0d pixels sent over random and edge-size frames, %0d filtered beats checked",
             sent, sb.beats);
    $display("kernels 0..15, small and clamped geometries, long output stall exercised");
    if (sb.errors == 0 && sb.exp_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d beats missing", sb.errors, sb.exp_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
